[rtl/lbs_pkg.sv]
// Package for the skinning block: widths, defaults, shared types.
// No dependencies.
`timescale 1ns / 1ps
package lbs_pkg;
	localparam int NUM_BONES_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WEIGHT_FRAC = 16;
	localparam int WORDS = 12;
	localparam int WORD_W = 4;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_INFL = 1'b1;

	typedef struct packed {
		logic                func;
		logic [5:0]          bone_index;
		logic [3:0]          word_index;
		logic signed [31:0]  word_value;
		logic [16:0]         weight;
		logic                last_influence;
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic signed [31:0]  pos_z;
		logic signed [31:0]  norm_x;
		logic signed [31:0]  norm_y;
		logic signed [31:0]  norm_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_norm_x;
		logic signed [31:0] out_norm_y;
		logic signed [31:0] out_norm_z;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLEND,
		ST_XFORM,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage

[rtl/lbs_if.sv]
// Valid/ready channel interfaces for the skinning block.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
interface lbs_in_if;
	logic valid;
	logic ready;
	lbs_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lbs_out_if;
	logic valid;
	logic ready;
	lbs_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/linear_blend_skinning.sv]
// Linear blend skinning over a bone palette held in a registered-read memory.
// Load item: writes one palette word. Influence: one palette word read per cycle,
// one multiply-add per word; last influence adds a transform, one row per cycle,
// and a hand-off state; the transform holds while a prior result waits.
// Reset clears control and the blended matrix; the palette is not cleared.
// Depends on lbs_pkg and lbs_if.
`timescale 1ns / 1ps
module linear_blend_skinning #(
	parameter int NUM_BONES = lbs_pkg::NUM_BONES_DEF,
	parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	lbs_in_if.sink in_ch,
	lbs_out_if.source out_ch
);
	import lbs_pkg::*;

	localparam int DEPTH = NUM_BONES * WORDS;
	localparam int AW = $clog2(DEPTH + 1);

	logic signed [31:0] pal_mem [DEPTH];
	logic signed [31:0] rd_q;
	logic signed [31:0] blend_q [WORDS];
	state_t state_q, state_d;
	in_item_t item_q;
	logic expect_first_q;
	logic [WORD_W-1:0] cnt_q;
	logic [WORD_W-1:0] idx_s1;
	logic vld_s1;
	logic [2:0] xc_q;
	logic signed [31:0] res_q [6];
	logic out_valid_q;

	logic in_fire, bone_ok, rd_en, xf_go;
	logic [AW-1:0] wr_addr, rd_addr;
	logic signed [31:0] m_s1;
	logic signed [63:0] prod, term64;
	logic signed [31:0] term;
	logic signed [31:0] acc;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign bone_ok = (item_q.bone_index < NUM_BONES);
	assign wr_addr = AW'(in_ch.data.bone_index * WORDS + in_ch.data.word_index);
	assign rd_addr = AW'(item_q.bone_index * WORDS + cnt_q);
	assign rd_en = (state_q == ST_BLEND) && (cnt_q < WORD_W'(WORDS));
	assign xf_go = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk) begin
		if (in_fire && in_ch.data.func == FUNC_LOAD
				&& in_ch.data.bone_index < NUM_BONES
				&& in_ch.data.word_index < WORD_W'(WORDS))
			pal_mem[wr_addr] <= in_ch.data.word_value;
		if (rd_en && bone_ok)
			rd_q <= pal_mem[rd_addr];
	end

	assign m_s1 = bone_ok ? rd_q : 32'sd0;
	assign prod = m_s1 * $signed({1'b0, item_q.weight});
	assign term64 = prod >>> WEIGHT_FRAC;
	assign term = sat32(term64);
	assign acc = sat32(64'(blend_q[idx_s1]) + 64'(term));

	// transform: xc 0..2 position rows, 3..5 normal rows
	logic [1:0] row;
	logic is_pos;
	logic signed [31:0] v0, v1, v2;
	logic signed [63:0] p0, p1, p2, tsum;
	assign is_pos = (xc_q < 3'd3);
	assign row = is_pos ? xc_q[1:0] : 2'(xc_q - 3'd3);
	assign v0 = is_pos ? item_q.pos_x : item_q.norm_x;
	assign v1 = is_pos ? item_q.pos_y : item_q.norm_y;
	assign v2 = is_pos ? item_q.pos_z : item_q.norm_z;
	assign p0 = (blend_q[{row, 2'd0}] * 64'(v0)) >>> FRAC_BITS;
	assign p1 = (blend_q[{row, 2'd1}] * 64'(v1)) >>> FRAC_BITS;
	assign p2 = (blend_q[{row, 2'd2}] * 64'(v2)) >>> FRAC_BITS;
	assign tsum = p0 + p1 + p2 + (is_pos ? 64'(blend_q[{row, 2'd3}]) : 64'sd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire && in_ch.data.func == FUNC_INFL) state_d = ST_BLEND;
			ST_BLEND: if (vld_s1 && idx_s1 == WORD_W'(WORDS - 1))
				state_d = item_q.last_influence ? ST_XFORM : ST_IDLE;
			ST_XFORM: if (xc_q == 3'd5 && xf_go) state_d = ST_OUT;
			ST_OUT: if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			expect_first_q <= 1'b1;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
			xc_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WORDS; i++) blend_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_ch.ready) out_valid_q <= 1'b0;
			if (in_fire) begin
				item_q <= in_ch.data;
				cnt_q <= '0;
			end
			vld_s1 <= rd_en;
			idx_s1 <= cnt_q;
			if (rd_en) cnt_q <= cnt_q + 1'b1;
			if (vld_s1)
				blend_q[idx_s1] <= expect_first_q ? term : acc;
			if (state_q == ST_BLEND && state_d != ST_BLEND) begin
				expect_first_q <= item_q.last_influence;
				xc_q <= '0;
			end
			if (state_q == ST_XFORM && xf_go) begin
				res_q[xc_q] <= sat32(tsum);
				xc_q <= xc_q + 1'b1;
			end
			if (state_q == ST_OUT && state_d == ST_IDLE) out_valid_q <= 1'b1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = '{res_q[0], res_q[1], res_q[2], res_q[3], res_q[4], res_q[5]};

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_rd_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> idx_s1 < WORD_W'(WORDS)) else $error("blend index out of range");
	a_xform_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_XFORM |-> xc_q < 3'd6) else $error("transform overrun");
`endif
endmodule

[dv/tb_top.sv]
// Self-checking bench for linear_blend_skinning: palette loads, weighted
// blends and vertex transforms, checked against an in-bench predictor.
// Depends on lbs_pkg, lbs_if and the block itself.
`timescale 1ns / 1ps
module tb_top;
	import lbs_pkg::*;

	localparam int NBONES = 64;
	localparam int FRAC = 16;
	localparam int LIMIT = 900000;
	localparam int HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	lbs_in_if in_ch();
	lbs_out_if out_ch();

	linear_blend_skinning dut(
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	logic signed [31:0] palette [NBONES][WORDS];
	logic [WORDS-1:0] word_written [NBONES];
	logic signed [31:0] blend_mtx [WORDS];
	bit first_infl = 1'b1;
	out_item_t skin_q[$];
	int errors = 0;
	int cycles = 0;
	int hold_cycles = 0;
	bit hold_req = 1'b0;
	bit calm = 1'b0;

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	task automatic predict_skin(input in_item_t it);
		logic signed [63:0] ms, ws, prod;
		logic signed [65:0] acc;
		logic signed [31:0] term;
		logic signed [31:0] pv [3];
		logic signed [31:0] nv [3];
		logic signed [31:0] res [6];
		out_item_t r;
		if (it.func == FUNC_LOAD) begin
			if (it.word_index < WORDS) begin
				palette[it.bone_index][it.word_index] = it.word_value;
				word_written[it.bone_index][it.word_index] = 1'b1;
			end
			return;
		end
		ws = {47'b0, it.weight};
		for (int i = 0; i < WORDS; i++) begin
			ms = 64'(palette[it.bone_index][i]);
			prod = ms * ws;
			term = clamp32(66'(prod >>> WEIGHT_FRAC));
			if (first_infl) blend_mtx[i] = term;
			else blend_mtx[i] = clamp32(66'(blend_mtx[i]) + 66'(term));
		end
		if (!it.last_influence) begin
			first_infl = 1'b0;
			return;
		end
		first_infl = 1'b1;
		pv = '{it.pos_x, it.pos_y, it.pos_z};
		nv = '{it.norm_x, it.norm_y, it.norm_z};
		for (int row = 0; row < 3; row++) begin
			acc = 66'(blend_mtx[row*4+3]);
			for (int c = 0; c < 3; c++) begin
				ms = 64'(blend_mtx[row*4+c]);
				ws = 64'(pv[c]);
				prod = ms * ws;
				acc = acc + 66'(prod >>> FRAC);
			end
			res[row] = clamp32(acc);
			acc = '0;
			for (int c = 0; c < 3; c++) begin
				ms = 64'(blend_mtx[row*4+c]);
				ws = 64'(nv[c]);
				prod = ms * ws;
				acc = acc + 66'(prod >>> FRAC);
			end
			res[3+row] = clamp32(acc);
		end
		r.out_pos_x = res[0];
		r.out_pos_y = res[1];
		r.out_pos_z = res[2];
		r.out_norm_x = res[3];
		r.out_norm_y = res[4];
		r.out_norm_z = res[5];
		skin_q.push_back(r);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// send one item; hold valid until accepted
	task automatic send_item(input in_item_t it);
		bit rdy;
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		predict_skin(it);
		if (!calm && $urandom_range(99) < 24) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'sh7fffffff - $urandom_range(3);
			2: return 32'sh80000000 + $urandom_range(3);
			default: return $signed($urandom_range(262143)) - 32'sd131072;
		endcase
	endfunction

	function automatic in_item_t load_item(input int b, input int w, input logic signed [31:0] v);
		in_item_t it;
		it = '0;
		it.func = FUNC_LOAD;
		it.bone_index = 6'(b);
		it.word_index = 4'(w);
		it.word_value = v;
		it.weight = 17'($urandom);
		it.pos_x = $urandom;
		it.norm_z = $urandom;
		return it;
	endfunction

	function automatic in_item_t infl_item(input int b, input int wt, input bit lst);
		in_item_t it;
		it = '0;
		it.func = FUNC_INFL;
		it.bone_index = 6'(b);
		it.word_index = 4'($urandom);
		it.word_value = $urandom;
		it.weight = 17'(wt);
		it.last_influence = lst;
		it.pos_x = rand_coord();
		it.pos_y = rand_coord();
		it.pos_z = rand_coord();
		it.norm_x = rand_coord();
		it.norm_y = rand_coord();
		it.norm_z = rand_coord();
		return it;
	endfunction

	function automatic int rand_weight();
		case ($urandom_range(9))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(131071);
			default: return $urandom_range(65536);
		endcase
	endfunction

	function automatic int pick_bone();
		int b;
		for (int n = 0; n < 200; n++) begin
			b = $urandom_range(NBONES - 1);
			if (&word_written[b]) return b;
		end
		return 0;
	endfunction

	task automatic drain(input int pause);
		while (skin_q.size() != 0) @(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	task automatic test_directed();
		logic signed [31:0] v;
		for (int w = 0; w < WORDS; w++) begin
			case (w % 4)
				0: v = 32'sh7fffffff;
				1: v = 32'sh80000000;
				2: v = 32'sh00010000;
				default: v = -32'sh00018000;
			endcase
			send_item(load_item(0, w, v));
		end
		send_item(load_item(0, 15, 32'sh12345678));
		send_item(load_item(63, 13, 32'sh0));
		send_item(infl_item(0, 65536, 1'b1));
		send_item(infl_item(0, 0, 1'b1));
		send_item(infl_item(0, 131071, 1'b1));
		send_item(infl_item(0, 65536, 1'b0));
		send_item(infl_item(0, 65536, 1'b0));
		send_item(infl_item(0, 1, 1'b1));
		send_item(infl_item(0, 32768, 1'b0));
		send_item(infl_item(0, 32768, 1'b1));
	endtask

	task automatic test_random(input int budget);
		int sent, b, n;
		sent = 0;
		while (sent < budget) begin
			if (sent > budget / 3 && sent < budget / 2) calm = 1'b1;
			else calm = 1'b0;
			case ($urandom_range(9))
				0: begin
					b = $urandom_range(NBONES - 1);
					for (int w = 0; w < WORDS; w++)
						send_item(load_item(b, w, rand_coord()));
					sent += WORDS;
				end
				1: begin
					send_item(load_item($urandom_range(NBONES - 1), $urandom_range(15),
						$urandom));
					sent++;
				end
				default: begin
					n = $urandom_range(1, 4);
					for (int k = 0; k < n; k++)
						send_item(infl_item(pick_bone(), rand_weight(), k == n - 1));
					sent += n;
				end
			endcase
		end
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		calm = 1'b1;
		for (int k = 0; k < 40; k++)
			send_item(infl_item(pick_bone(), rand_weight(), k % 2 == 1));
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_req && hold_cycles < HOLD_LEN) begin
			hold_cycles <= hold_cycles + 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
		end
	end

	// valid and ready are stable between edges
	always @(negedge clk) begin
		out_item_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (skin_q.size() == 0) begin
				report("unexpected result", got.out_pos_x, 32'h0);
			end else begin
				want = skin_q.pop_front();
				if (got.out_pos_x !== want.out_pos_x) report("pos_x", got.out_pos_x, want.out_pos_x);
				if (got.out_pos_y !== want.out_pos_y) report("pos_y", got.out_pos_y, want.out_pos_y);
				if (got.out_pos_z !== want.out_pos_z) report("pos_z", got.out_pos_z, want.out_pos_z);
				if (got.out_norm_x !== want.out_norm_x)
					report("norm_x", got.out_norm_x, want.out_norm_x);
				if (got.out_norm_y !== want.out_norm_y)
					report("norm_y", got.out_norm_y, want.out_norm_y);
				if (got.out_norm_z !== want.out_norm_z)
					report("norm_z", got.out_norm_z, want.out_norm_z);
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		for (int b = 0; b < NBONES; b++) word_written[b] = '0;
		for (int i = 0; i < WORDS; i++) blend_mtx[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1500);
		test_backpressure();
		in_ch.valid <= 1'b0;
		drain(40);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
